// ===== hw/rtl/next_prime_search_defines.svh =====
// ---------------------------------------------------------------------------
// next_prime_search_defines.svh
// Assertion macros used by the next prime search controller (nps_ctrl).
// ---------------------------------------------------------------------------
`ifndef NEXT_PRIME_SEARCH_DEFINES_SVH
`define NEXT_PRIME_SEARCH_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("next_prime_search: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next_prime_search: next-cycle check failed");

`endif

// ===== hw/rtl/nps_pkg.sv =====
// ---------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the next prime search block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nps_pkg;

  // Width of the result word.
  localparam int PRIME_W = 31;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture input word as first candidate
    logic inc_cand;   // advance candidate by one
    logic init_div;   // divisor = 3, square = 9
    logic next_div;   // divisor += 2, square updated
    logic div_start;  // clear remainder, load dividend shifter
    logic div_step;   // one restoring division step
    logic out_load;   // write candidate to output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic cand_is_two;
    logic cand_even;
    logic sq_gt_cand;
    logic div_busy;
    logic div_last;
    logic rem_zero;
    logic out_full;
  } sts_t;

endpackage

// ===== hw/rtl/nps_datapath.sv =====
// ---------------------------------------------------------------------------
// nps_datapath
// Candidate, divisor, running square, bit-serial remainder unit and the
// output register of the next prime search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nps_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  nps_pkg::cmd_t                cmd,
  output nps_pkg::sts_t                sts,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [nps_pkg::PRIME_W-1:0]  prime
);

  localparam int DW = (VALUE_BITS + 1) / 2 + 1;
  localparam int SW = VALUE_BITS + 2;
  localparam int CNTW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] cand;
  logic [DW-1:0]         div;
  logic [SW-1:0]         sq;
  logic [DW-1:0]         rem;
  logic [VALUE_BITS-1:0] shf;
  logic [CNTW-1:0]       cnt;

  logic [VALUE_BITS-1:0] raw;
  logic                  small_in;
  logic [DW:0]           trial;
  logic [DW:0]           trial_sub;

  assign raw      = $unsigned(value);
  // Negative, zero or one all map to 2.
  assign small_in = raw[VALUE_BITS-1] | (raw[VALUE_BITS-1:1] == '0);

  assign trial     = {rem, shf[VALUE_BITS-1]};
  assign trial_sub = trial - {1'b0, div};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand <= small_in ? VALUE_BITS'(2) : raw;
    end else if (cmd.inc_cand) begin
      cand <= cand + VALUE_BITS'(1);
    end

    if (cmd.init_div) begin
      div <= DW'(3);
      sq  <= SW'(9);
    end else if (cmd.next_div) begin
      // (d+2)^2 = d^2 + 4d + 4
      div <= div + DW'(2);
      sq  <= sq + (SW'(div) << 2) + SW'(4);
    end

    if (cmd.div_start) begin
      rem <= '0;
      shf <= cand;
    end else if (cmd.div_step) begin
      rem <= trial_sub[DW] ? trial[DW-1:0] : trial_sub[DW-1:0];
      shf <= shf << 1;
    end

    if (cmd.out_load) begin
      prime <= nps_pkg::PRIME_W'(cand);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.div_start) begin
        cnt <= CNTW'(VALUE_BITS);
      end else if (cmd.div_step) begin
        cnt <= cnt - CNTW'(1);
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.cand_is_two = (cand == VALUE_BITS'(2));
    sts.cand_even   = ~cand[0];
    sts.sq_gt_cand  = (sq > SW'(cand));
    sts.div_busy    = (cnt != '0);
    sts.div_last    = (cnt == CNTW'(1));
    sts.rem_zero    = (rem == '0);
    sts.out_full    = out_valid;
  end

endmodule

// ===== hw/rtl/nps_ctrl.sv =====
// ---------------------------------------------------------------------------
// nps_ctrl
// Sequencer for the next prime search: candidate checks, divisor loop and
// bit-serial division steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "next_prime_search_defines.svh"

module nps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  nps_pkg::sts_t sts,
  output nps_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TEST,
    S_DIV,
    S_EVAL,
    S_FOUND
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (sts.cand_is_two) begin
          state_next = S_FOUND;
        end else if (sts.cand_even) begin
          cmd.inc_cand = 1'b1;
        end else begin
          cmd.init_div = 1'b1;
          state_next   = S_TEST;
        end
      end
      S_TEST: begin
        // Divisor square past the candidate: no factor left.
        if (sts.sq_gt_cand) begin
          state_next = S_FOUND;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.rem_zero) begin
          cmd.inc_cand = 1'b1;
          state_next   = S_CHECK;
        end else begin
          cmd.next_div = 1'b1;
          state_next   = S_TEST;
        end
      end
      S_FOUND: begin
        // Hold until the output register is free.
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `NPS_ASSERT_NOW(a_div_busy, state == S_DIV, sts.div_busy)
  `NPS_ASSERT_NEXT(a_test_to_div, state == S_TEST && !sts.sq_gt_cand, state == S_DIV)
  `NPS_ASSERT_NEXT(a_load_fills_out, cmd.out_load, sts.out_full && state == S_IDLE)

endmodule

// ===== hw/rtl/next_prime_search.sv =====
// ---------------------------------------------------------------------------
// next_prime_search
// Smallest prime not less than a signed start value, by trial division.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_ready with the signed word value. Output
// channel: out_valid/out_ready with the word prime. Values of 1 or below
// give 2.
// One word is processed at a time. Each candidate is checked first;
// each odd candidate then runs a divisor loop in which every divisor d
// (3, 5, 7, ... while d*d <= candidate, until one divides it) is tried
// by the one-bit-per-cycle restoring remainder unit. The candidate 2
// skips the divisor loop.
// The result sits in an output register, so in_ready returns as soon as
// the word is written there; a following search runs while the receiver
// stalls and waits in its final state only if the register is still full.
// Reset (rst, synchronous) drops any search in flight and empties the
// output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module next_prime_search #(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [nps_pkg::PRIME_W-1:0]  prime
);

  nps_pkg::cmd_t cmd;
  nps_pkg::sts_t sts;

  nps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nps_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .prime     (prime)
  );

endmodule
